// ----- hdl/gdfr_pkg.sv -----
// ----------------------------------------------------------------------------
// gdfr_pkg
// grid size, derived widths, action codes and sequencer states for the reachability unit
// ----------------------------------------------------------------------------
package gdfr_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COORD_W = 10;
  localparam int XW      = (GRID_WIDTH  > 2) ? $clog2(GRID_WIDTH)  : 1;
  localparam int ROW_W   = (GRID_HEIGHT > 2) ? $clog2(GRID_HEIGHT) : 1;
  localparam int EXT_W   = COORD_W + 2;

  localparam logic ACTION_WRITE = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_READ,
    S_WR_WRITE,
    S_Q_READ,
    S_Q_EVAL,
    S_DONE
  } state_t;

endpackage

// ----- hdl/gdfr_req_if.sv -----
// ----------------------------------------------------------------------------
// gdfr_req_if
// request channel: cell writes and reachability queries
// ----------------------------------------------------------------------------
interface gdfr_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [9:0] cell_x;
  logic [9:0] cell_y;
  logic       blocked;
  logic [9:0] target_x;
  logic [9:0] target_y;

  modport source (
    output valid, action, cell_x, cell_y, blocked, target_x, target_y,
    input  ready
  );
  modport sink (
    input  valid, action, cell_x, cell_y, blocked, target_x, target_y,
    output ready
  );
endinterface

// ----- hdl/gdfr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gdfr_rsp_if
// response channel: write acknowledge or query answer
// ----------------------------------------------------------------------------
interface gdfr_rsp_if;
  logic valid;
  logic ready;
  logic is_query_answer;
  logic connected;

  modport source (
    output valid, is_query_answer, connected,
    input  ready
  );
  modport sink (
    input  valid, is_query_answer, connected,
    output ready
  );
endinterface

// ----- hdl/grid_diagonal_first_reachability_unit.sv -----
// ----------------------------------------------------------------------------
// grid_diagonal_first_reachability_unit
// occupancy bitmap with a diagonal-first walk checker, one step at a time
// ----------------------------------------------------------------------------
// write item: a row read, a row write and done between accept and result
// query item: each walk step is a dual row read then a check and move, for up to
//   max(|dx|,|dy|) steps; the bitmap row read sets the step pace
// one item at a time; a finished result waits in the output register
// reset: a clearing pass writes GRID_HEIGHT rows before the first
//   item is accepted
module grid_diagonal_first_reachability_unit
  import gdfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  gdfr_req_if.sink          req,
  gdfr_rsp_if.source        rsp
);

  state_t state, state_next;

  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] row_a, row_b, wr_row;

  logic [ROW_W-1:0]   clr_cnt;
  logic               blk;
  logic [COORD_W-1:0] x, y, tx, ty;
  logic               res_q, res_conn;

  logic               accept, rsp_free;
  logic [1:0]         sx, sy;
  logic [EXT_W-1:0]   nx, ny;
  logic               x_ok, y_ok, nx_ok, ny_ok;
  logic               wr_ok, step_ok, at_target, next_at_target;

  assign accept   = req.valid && req.ready;
  assign rsp_free = !rsp.valid || rsp.ready;

  // step direction and neighbor coordinates; a step below zero wraps high
  always_comb begin
    sx = (tx > x) ? 2'b01 : ((tx < x) ? 2'b11 : 2'b00);
    sy = (ty > y) ? 2'b01 : ((ty < y) ? 2'b11 : 2'b00);
    nx = {2'b00, x} + {{(EXT_W-2){sx[1]}}, sx};
    ny = {2'b00, y} + {{(EXT_W-2){sy[1]}}, sy};
    x_ok  = {2'b00, x} < EXT_W'(GRID_WIDTH);
    y_ok  = {2'b00, y} < EXT_W'(GRID_HEIGHT);
    nx_ok = nx < EXT_W'(GRID_WIDTH);
    ny_ok = ny < EXT_W'(GRID_HEIGHT);
  end

  always_comb begin
    logic c_vert, c_horiz, c_diag;
    c_vert  = x_ok  && ny_ok && !row_b[x[XW-1:0]];
    c_horiz = nx_ok && y_ok  && !row_a[nx[XW-1:0]];
    c_diag  = nx_ok && ny_ok && !row_b[nx[XW-1:0]];
    step_ok = c_vert && c_horiz && c_diag;
  end

  assign at_target      = (x == tx) && (y == ty);
  assign next_at_target = (nx[COORD_W-1:0] == tx) && (ny[COORD_W-1:0] == ty);
  assign wr_ok          = x_ok && y_ok;

  always_comb begin
    wr_row = row_a;
    wr_row[x[XW-1:0]] = blk;
  end

  // bitmap: one row per entry, two registered read ports
  always_ff @(posedge clk) begin
    row_a <= mem[y[ROW_W-1:0]];
    row_b <= mem[ny[ROW_W-1:0]];
    if (state == S_CLEAR) begin
      mem[clr_cnt] <= '0;
    end else if (state == S_WR_WRITE && wr_ok) begin
      mem[y[ROW_W-1:0]] <= wr_row;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == ROW_W'(GRID_HEIGHT - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (req.action == ACTION_WRITE) begin
            state_next = S_WR_READ;
          end else if (req.cell_x == req.target_x && req.cell_y == req.target_y) begin
            state_next = S_DONE;
          end else begin
            state_next = S_Q_READ;
          end
        end
      end
      S_WR_READ:  state_next = S_WR_WRITE;
      S_WR_WRITE: state_next = S_DONE;
      S_Q_READ:   state_next = S_Q_EVAL;
      S_Q_EVAL: begin
        if (!step_ok || next_at_target) state_next = S_DONE;
        else state_next = S_Q_READ;
      end
      S_DONE: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // handshake outputs
  always_comb begin
    req.ready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // walk and item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x <= '0;
      y <= '0;
    end else if (accept) begin
      x <= req.cell_x;
      y <= req.cell_y;
    end else if (state == S_Q_EVAL && step_ok) begin
      x <= nx[COORD_W-1:0];
      y <= ny[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk      <= req.blocked;
      tx       <= req.target_x;
      ty       <= req.target_y;
      res_q    <= req.action;
      res_conn <= (req.action == ACTION_QUERY);
    end else if (state == S_Q_EVAL) begin
      res_conn <= step_ok;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.is_query_answer <= res_q;
      rsp.connected       <= res_q && res_conn;
    end
  end

  // a step is only evaluated while the walk is short of the target
  a_eval_not_at_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_EVAL) |-> !at_target)
    else $error("walk step evaluated at target");

  // a write acknowledge never reports connected
  a_ack_not_connected: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.is_query_answer) |-> !rsp.connected)
    else $error("write acknowledge with connected set");

  // a walk step moves the column by at most one
  a_unit_step: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_Q_EVAL && state == S_Q_READ) |->
      (($past(x) - x == 10'd1) || (x - $past(x) == 10'd1) || (x == $past(x))))
    else $error("walk moved more than one column");

endmodule

// ----- verif/grid_diagonal_first_reachability_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_diagonal_first_reachability_unit_tb
// drives cell writes and diagonal-first reachability queries into the unit
// with random gaps and back-pressure, keeps its own occupancy map, predicts
// every acknowledge and answer, and checks them in order
// ----------------------------------------------------------------------------
module grid_diagonal_first_reachability_unit_tb
  import gdfr_pkg::*;
();

  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct packed {
    logic       action;
    logic [9:0] cell_x;
    logic [9:0] cell_y;
    logic       blocked;
    logic [9:0] target_x;
    logic [9:0] target_y;
  } grid_request_t;

  typedef struct packed {
    logic is_query_answer;
    logic connected;
  } grid_answer_t;

  class reach_scoreboard;
    bit           blocked_cells [CELL_COUNT];
    grid_answer_t answers_due [$];
    int           errors;

    // anything off the grid counts as blocked
    function bit cell_open(int x, int y);
      if (x < 0 || y < 0 || x >= GRID_WIDTH || y >= GRID_HEIGHT) return 1'b0;
      return !blocked_cells[y * GRID_WIDTH + x];
    endfunction

    function bit walk_clear(int x, int y, int tx, int ty);
      int sx;
      int sy;
      while (x != tx || y != ty) begin
        sx = (tx > x) ? 1 : ((tx < x) ? -1 : 0);
        sy = (ty > y) ? 1 : ((ty < y) ? -1 : 0);
        if (!(cell_open(x, y + sy) && cell_open(x + sx, y) &&
              cell_open(x + sx, y + sy))) return 1'b0;
        x += sx;
        y += sy;
      end
      return 1'b1;
    endfunction

    function void note_request(grid_request_t item);
      grid_answer_t ans;
      if (item.action == ACTION_WRITE) begin
        if (item.cell_x < GRID_WIDTH && item.cell_y < GRID_HEIGHT)
          blocked_cells[int'(item.cell_y) * GRID_WIDTH + int'(item.cell_x)] = item.blocked;
        ans.is_query_answer = 1'b0;
        ans.connected       = 1'b0;
      end else begin
        ans.is_query_answer = 1'b1;
        ans.connected = walk_clear(int'(item.cell_x), int'(item.cell_y),
                                   int'(item.target_x), int'(item.target_y));
      end
      answers_due = {answers_due, ans};
    endfunction

    function void check_answer(logic is_query_answer, logic connected);
      grid_answer_t want;
      if (answers_due.size() == 0) begin
        $error("unexpected result: is_query_answer %0b connected %0b",
               is_query_answer, connected);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (is_query_answer !== want.is_query_answer) begin
        $error("field is_query_answer: expected %0b actual %0b",
               want.is_query_answer, is_query_answer);
        errors++;
      end
      if (connected !== want.connected) begin
        $error("field connected: expected %0b actual %0b", want.connected, connected);
        errors++;
      end
    endfunction

    function void check_drained();
      if (answers_due.size() != 0) begin
        $error("%0d results never arrived", answers_due.size());
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  bit   quiet_send;
  bit   quiet_recv;

  reach_scoreboard sb = new;

  gdfr_req_if req_ch ();
  gdfr_rsp_if rsp_ch ();

  grid_diagonal_first_reachability_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high after an accept; the next call either lowers it or
  // replaces the item in the same step
  task automatic send_item(input grid_request_t item);
    int gap;
    if ($urandom_range(0, 15) == 0) quiet_send = !quiet_send;
    gap = quiet_send ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= item.action;
    req_ch.cell_x   <= item.cell_x;
    req_ch.cell_y   <= item.cell_y;
    req_ch.blocked  <= item.blocked;
    req_ch.target_x <= item.target_x;
    req_ch.target_y <= item.target_y;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(item);
  endtask

  task automatic send_fields(input logic action, input int cx, input int cy,
                             input logic blk, input int tx, input int ty);
    grid_request_t item;
    item.action   = action;
    item.cell_x   = cx[9:0];
    item.cell_y   = cy[9:0];
    item.blocked  = blk;
    item.target_x = tx[9:0];
    item.target_y = ty[9:0];
    send_item(item);
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic grid_request_t random_item();
    grid_request_t item;
    int pick;
    int sx;
    int sy;
    pick = $urandom_range(0, 99);
    item.action   = ACTION_QUERY;
    item.cell_x   = 10'($urandom);
    item.cell_y   = 10'($urandom);
    item.blocked  = 1'($urandom);
    item.target_x = 10'($urandom);
    item.target_y = 10'($urandom);
    if (pick < 45) begin
      // in-grid write, mostly clearing so the map stays sparse
      item.action  = ACTION_WRITE;
      item.cell_x  = 10'($urandom_range(0, GRID_WIDTH - 1));
      item.cell_y  = 10'($urandom_range(0, GRID_HEIGHT - 1));
      item.blocked = ($urandom_range(0, 3) == 0);
    end else if (pick < 50) begin
      item.action = ACTION_WRITE;
    end else if (pick < 80) begin
      // short walk near the start, may step off the edge
      sx = $urandom_range(0, GRID_WIDTH - 1);
      sy = $urandom_range(0, GRID_HEIGHT - 1);
      item.cell_x = sx[9:0];
      item.cell_y = sy[9:0];
      if ($urandom_range(0, 19) == 0) begin
        item.target_x = sx[9:0];
        item.target_y = sy[9:0];
      end else begin
        item.target_x = 10'(sx + $urandom_range(0, 20) - 10);
        item.target_y = 10'(sy + $urandom_range(0, 20) - 10);
      end
    end else if (pick < 92) begin
      item.cell_x   = 10'($urandom_range(0, GRID_WIDTH - 1));
      item.cell_y   = 10'($urandom_range(0, GRID_HEIGHT - 1));
      item.target_x = 10'($urandom_range(0, GRID_WIDTH - 1));
      item.target_y = 10'($urandom_range(0, GRID_HEIGHT - 1));
    end
    return item;
  endfunction

  initial begin
    rst             <= 1'b1;
    cycles          <= 0;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACTION_WRITE;
    req_ch.cell_x   <= '0;
    req_ch.cell_y   <= '0;
    req_ch.blocked  <= 1'b0;
    req_ch.target_x <= '0;
    req_ch.target_y <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty grid: same cell, full diagonals, straight column
    send_fields(ACTION_QUERY, 0, 0, 1'b1, 0, 0);
    send_fields(ACTION_QUERY, 0, 0, 1'b0, 63, 63);
    send_fields(ACTION_QUERY, 63, 0, 1'b0, 0, 63);
    send_fields(ACTION_QUERY, 0, 5, 1'b0, 0, 40);
    // one blocked cell hit on the diagonal, from its own cell, and on a row
    send_fields(ACTION_WRITE, 10, 10, 1'b1, 1023, 1023);
    send_fields(ACTION_QUERY, 8, 8, 1'b0, 12, 12);
    send_fields(ACTION_QUERY, 10, 10, 1'b0, 10, 15);
    send_fields(ACTION_QUERY, 10, 10, 1'b0, 10, 10);
    send_fields(ACTION_QUERY, 11, 9, 1'b0, 9, 11);
    send_fields(ACTION_QUERY, 5, 10, 1'b0, 20, 10);
    send_fields(ACTION_QUERY, 5, 11, 1'b0, 20, 11);
    // writes off the grid are dropped, walks off the grid fail
    send_fields(ACTION_WRITE, 64, 0, 1'b1, 0, 0);
    send_fields(ACTION_WRITE, 1023, 1023, 1'b1, 0, 0);
    send_fields(ACTION_QUERY, 60, 0, 1'b0, 63, 0);
    send_fields(ACTION_QUERY, 62, 0, 1'b0, 70, 0);
    send_fields(ACTION_QUERY, 1023, 1023, 1'b1, 1023, 1023);
    send_fields(ACTION_QUERY, 1023, 1023, 1'b0, 0, 0);
    send_fields(ACTION_WRITE, 10, 10, 1'b0, 0, 0);
    send_fields(ACTION_QUERY, 8, 8, 1'b0, 12, 12);
    // blocked corners
    send_fields(ACTION_WRITE, 0, 0, 1'b1, 0, 0);
    send_fields(ACTION_WRITE, 63, 63, 1'b1, 0, 0);
    send_fields(ACTION_QUERY, 1, 1, 1'b0, 0, 0);
    send_fields(ACTION_QUERY, 0, 1, 1'b0, 0, 0);
    send_fields(ACTION_QUERY, 5, 5, 1'b0, 63, 63);
    send_fields(ACTION_WRITE, 0, 0, 1'b0, 0, 0);
    send_fields(ACTION_WRITE, 63, 63, 1'b0, 0, 0);
    wait_results_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_results_drained();
      send_item(random_item());
    end
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      if ($urandom_range(0, 15) == 0) quiet_recv = !quiet_recv;
      stall = quiet_recv ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1 || rst);
      sb.check_answer(rsp_ch.is_query_answer, rsp_ch.connected);
    end
  end

endmodule

// ----- files.f -----
hdl/gdfr_pkg.sv
hdl/gdfr_req_if.sv
hdl/gdfr_rsp_if.sv
hdl/grid_diagonal_first_reachability_unit.sv
verif/grid_diagonal_first_reachability_unit_tb.sv
